FILE: rtl/core/stfp_pkg.sv
// Shared types and constants for the sync/trailer frame parser.
`default_nettype none

package stfp_pkg;

  localparam int WIN_LEN     = 24;
  localparam int FILL_W      = 5;
  localparam int PAY_BASE    = 2;
  localparam int NUM_OFFSETS = 4;
  localparam int NUM_CHAN    = 4;

  localparam logic [7:0] SYNC_HI  = 8'h01;
  localparam logic [7:0] SYNC_LO  = 8'h50;
  localparam logic [7:0] TRAIL_HI = 8'hFF;
  localparam logic [7:0] TRAIL_LO = 8'hFE;
  localparam logic [7:0] TOP_POS  = 8'h00;
  localparam logic [7:0] TOP_NEG  = 8'hFF;

  localparam logic [2:0] LAYOUT_LE = 3'd4;

  // queued byte with header flags worked out on the way in
  typedef struct packed {
    logic [7:0] data;
    logic       sync_hi;
    logic       sync_lo;
  } qentry_t;

  typedef struct packed {
    logic [NUM_CHAN-1:0][31:0] chan;
    logic [2:0]                layout;
  } result_t;

  typedef enum logic {
    ST_FILL,
    ST_SCAN
  } eng_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/stfp_ifs.sv
// Valid/ready stream interfaces for received bytes and decoded frames.
`default_nettype none

interface stfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stfp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] channel_one;
  logic signed [31:0] channel_two;
  logic signed [31:0] channel_three;
  logic signed [31:0] channel_four;
  logic        [2:0]  layout_used;

  modport source (output valid, output channel_one, output channel_two,
                  output channel_three, output channel_four, output layout_used,
                  input ready);
  modport sink   (input valid, input channel_one, input channel_two,
                  input channel_three, input channel_four, input layout_used,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/stfp_queue.sv
// Front end: accepts bytes, flags header bytes, and queues them for the engine.
`default_nettype none

module stfp_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  stfp_byte_if.sink        rx,
  output logic             q_valid,
  input  logic             q_ready,
  output stfp_pkg::qentry_t q_entry
);
  import stfp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qentry_t          mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;
  qentry_t          in_entry;

  assign rx.ready = (count != CNT_W'(DEPTH));
  assign q_valid  = (count != '0);
  assign q_entry  = mem[rd_ptr];
  assign push     = rx.valid && rx.ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    in_entry.data    = rx.rx_byte;
    in_entry.sync_hi = (rx.rx_byte == SYNC_HI);
    in_entry.sync_lo = (rx.rx_byte == SYNC_LO);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stfp_engine.sv
// Back end: 24-byte window, header walk, trailer check and channel decode.
`default_nettype none

module stfp_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  output logic              q_ready,
  input  stfp_pkg::qentry_t q_entry,
  stfp_result_if.source     frame
);
  import stfp_pkg::*;

  eng_state_t        state;
  eng_state_t        state_next;
  qentry_t           win [WIN_LEN];
  logic [FILL_W-1:0] fill;
  logic              out_valid;
  result_t           result;
  result_t           result_next;
  logic              do_load;
  logic              do_shift;
  logic              do_emit;
  logic              hdr_at_front;
  logic              trailer_ok;

  assign hdr_at_front = win[0].sync_hi && win[1].sync_lo;
  assign trailer_ok   = (win[WIN_LEN-2].data == TRAIL_HI) &&
                        (win[WIN_LEN-1].data == TRAIL_LO);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // In scan, one shift per cycle while the front two bytes are not a header.
  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    do_emit    = 1'b0;
    case (state)
      ST_FILL: begin
        q_ready = 1'b1;
        if (q_valid) begin
          do_load = 1'b1;
          if (fill == FILL_W'(WIN_LEN - 1)) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (fill == FILL_W'(1)) begin
          state_next = ST_FILL;
        end else if (hdr_at_front) begin
          if (fill == FILL_W'(WIN_LEN)) begin
            if (trailer_ok) begin
              if (!out_valid || frame.ready) begin
                do_emit    = 1'b1;
                state_next = ST_FILL;
              end
            end else begin
              do_shift   = 1'b1;
              state_next = ST_FILL;
            end
          end else begin
            state_next = ST_FILL;
          end
        end else begin
          do_shift = 1'b1;
        end
      end
      default: begin
        state_next = ST_FILL;
      end
    endcase
  end

  // Channel decode: first big-endian offset whose top bytes are all sign fill, else little-endian.
  always_comb begin
    logic [NUM_OFFSETS-1:0] off_ok;
    logic [7:0]             top;
    off_ok = '1;
    for (int o = 0; o < NUM_OFFSETS; o++) begin
      for (int k = 0; k < NUM_CHAN; k++) begin
        top = win[PAY_BASE + o + 4*k].data;
        if (!(top inside {TOP_POS, TOP_NEG})) begin
          off_ok[o] = 1'b0;
        end
      end
    end
    for (int k = 0; k < NUM_CHAN; k++) begin
      result_next.chan[k] = {win[PAY_BASE + 4*k + 3].data, win[PAY_BASE + 4*k + 2].data,
                             win[PAY_BASE + 4*k + 1].data, win[PAY_BASE + 4*k].data};
    end
    result_next.layout = LAYOUT_LE;
    for (int o = NUM_OFFSETS - 1; o >= 0; o--) begin
      if (off_ok[o]) begin
        for (int k = 0; k < NUM_CHAN; k++) begin
          result_next.chan[k] = {win[PAY_BASE + o + 4*k].data,
                                 win[PAY_BASE + o + 4*k + 1].data,
                                 win[PAY_BASE + o + 4*k + 2].data,
                                 win[PAY_BASE + o + 4*k + 3].data};
        end
        result_next.layout = 3'(o);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WIN_LEN; i++) begin
      if (do_load && fill == FILL_W'(i)) begin
        win[i] <= q_entry;
      end
    end
    if (do_shift) begin
      for (int i = 0; i < WIN_LEN - 1; i++) begin
        win[i] <= win[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (do_load) begin
      fill <= fill + 1'b1;
    end else if (do_shift) begin
      fill <= fill - 1'b1;
    end else if (do_emit) begin
      fill <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_emit) begin
      out_valid <= 1'b1;
    end else if (frame.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      result <= result_next;
    end
  end

  assign frame.valid         = out_valid;
  assign frame.channel_one   = $signed(result.chan[0]);
  assign frame.channel_two   = $signed(result.chan[1]);
  assign frame.channel_three = $signed(result.chan[2]);
  assign frame.channel_four  = $signed(result.chan[3]);
  assign frame.layout_used   = result.layout;

endmodule

`default_nettype wire

FILE: rtl/core/sync_trailer_frame_parser.sv
// Sync/trailer frame parser top level: byte queue feeding the window engine.
// Bytes enter a QUEUE_DEPTH-word queue at one word per cycle while it is not full.
// The engine takes one byte per cycle into its 24-byte window while filling and
// the queue holds a byte; the byte that completes the window starts a header walk
// that shifts the window one byte per cycle until 01 50 sits at the front or one
// byte is left. A frame (header at the front of a full window and FF FE at the end)
// yields one decoded result held in an output register; the queue keeps taking
// bytes while it has room and the engine walks or waits on the output.
`default_nettype none

module sync_trailer_frame_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  stfp_byte_if.sink     rx,
  stfp_result_if.source frame
);
  import stfp_pkg::*;

  logic    q_valid;
  logic    q_ready;
  qentry_t q_entry;

  stfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  stfp_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .frame   (frame)
  );

endmodule

`default_nettype wire
